/* src/priority_job_queue_assert.svh */
// ----------------------------------------------------------------------------
// priority_job_queue_assert.svh
// Assertion macros used by the checker file of the job queue.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_JOB_QUEUE_ASSERT_SVH
`define PRIORITY_JOB_QUEUE_ASSERT_SVH

// Clocked assertion, switched off while reset is low
`define PJQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds across reset
`define PJQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/pjq_pkg.sv */
// ----------------------------------------------------------------------------
// pjq_pkg
// Codes and control types of the sorted priority job queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pjq_pkg;

  localparam int MODE_BITS   = 2;
  localparam int STATUS_BITS = 3;

  typedef logic [MODE_BITS-1:0]   mode_t;
  typedef logic [STATUS_BITS-1:0] status_t;

  // request operations
  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_POP    = 2'd1;
  localparam mode_t MODE_SEARCH = 2'd2;

  // result status codes
  localparam status_t ST_DONE      = 3'd0;
  localparam status_t ST_EMPTY     = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_FOUND     = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic start;     // latch the accepted request and set up the walk
    logic run;       // walk is allowed to advance
    logic load_out;  // copy the result into the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done; // no read, write-back or head placement pending
  } dp_sts_t;

endpackage

`default_nettype wire

/* src/pjq_req_if.sv */
// ----------------------------------------------------------------------------
// pjq_req_if
// Request channel: valid/ready handshake with operation, id and priority.
// ----------------------------------------------------------------------------
`default_nettype none

interface pjq_req_if #(
  parameter int ID_BITS       = 16,
  parameter int PRIORITY_BITS = 8
);
  logic                     valid;
  logic                     ready;
  pjq_pkg::mode_t           mode;
  logic [ID_BITS-1:0]       job_id;
  logic [PRIORITY_BITS-1:0] priority_req;

  modport source (output valid, output mode, output job_id, output priority_req,
                  input ready);
  modport sink   (input valid, input mode, input job_id, input priority_req,
                  output ready);
endinterface

`default_nettype wire

/* src/pjq_rsp_if.sv */
// ----------------------------------------------------------------------------
// pjq_rsp_if
// Result channel: valid/ready handshake with status, popped id and occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

interface pjq_rsp_if #(
  parameter int ID_BITS  = 16,
  parameter int CNT_BITS = 5
);
  logic                 valid;
  logic                 ready;
  pjq_pkg::status_t     status;
  logic [ID_BITS-1:0]   popped_id;
  logic [CNT_BITS-1:0]  occupancy;

  modport source (output valid, output status, output popped_id, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input popped_id, input occupancy,
                  output ready);
endinterface

`default_nettype wire

/* src/pjq_ram.sv */
// ----------------------------------------------------------------------------
// pjq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pjq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/pjq_ctrl.sv */
// ----------------------------------------------------------------------------
// pjq_ctrl
// Controller: request handshake, walk sequencing and result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pjq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      pjq_pkg::dp_cmd_t cmd,
  input  wire pjq_pkg::dp_sts_t sts
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // commands to the datapath
  always_comb begin
    cmd.start    = (state_r == S_IDLE) && in_valid;
    cmd.run      = (state_r == S_RUN);
    cmd.load_out = (state_r == S_RUN) && sts.walk_done && (!out_valid_r || out_ready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_RUN;
      end
      S_RUN: begin
        if (cmd.load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result slot: filled on load, emptied when taken
  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/pjq_datapath.sv */
// ----------------------------------------------------------------------------
// pjq_datapath
// Entry RAM, count, walk pointers and result registers of the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pjq_datapath #(
  parameter int DEPTH         = 16,
  parameter int ID_BITS       = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pjq_pkg::dp_cmd_t              cmd,
  output      pjq_pkg::dp_sts_t              sts,
  input  wire pjq_pkg::mode_t                in_mode,
  input  wire logic [ID_BITS-1:0]            in_job_id,
  input  wire logic [PRIORITY_BITS-1:0]      in_priority,
  output      pjq_pkg::status_t              out_status,
  output      logic [ID_BITS-1:0]            out_popped_id,
  output      logic [$clog2(DEPTH+1)-1:0]    out_occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam int WW = ID_BITS + PRIORITY_BITS;

  // request being served
  pjq_pkg::mode_t           op_r, op_nxt;
  logic [ID_BITS-1:0]       key_id_r, key_id_nxt;
  logic [PRIORITY_BITS-1:0] key_pri_r, key_pri_nxt;

  // held job count
  logic [CW-1:0] cnt_r, cnt_nxt;

  // walk state
  logic          issuing_r, issuing_nxt;  // reads still to issue
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [AW-1:0] last_idx_r, last_idx_nxt;
  logic          pend_r, pend_nxt;        // read data arrives this cycle
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;
  logic          place_r, place_nxt;      // new job goes to the head

  // result of the request
  pjq_pkg::status_t   res_status_r, res_status_nxt;
  logic [ID_BITS-1:0] res_pop_r, res_pop_nxt;

  // output register
  pjq_pkg::status_t   out_status_r;
  logic [ID_BITS-1:0] out_pop_r;
  logic [CW-1:0]      out_occ_r;

  // RAM port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic          ram_re;
  logic [WW-1:0] ram_rdata;

  logic [ID_BITS-1:0]       rd_id;
  logic [PRIORITY_BITS-1:0] rd_pri;

  pjq_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  assign rd_id  = ram_rdata[WW-1:PRIORITY_BITS];
  assign rd_pri = ram_rdata[PRIORITY_BITS-1:0];

  assign sts.walk_done = !issuing_r && !pend_r && !place_r;

  assign out_status    = out_status_r;
  assign out_popped_id = out_pop_r;
  assign out_occupancy = out_occ_r;

  // setup, read issue and write-back
  always_comb begin
    op_nxt         = op_r;
    key_id_nxt     = key_id_r;
    key_pri_nxt    = key_pri_r;
    cnt_nxt        = cnt_r;
    issuing_nxt    = issuing_r;
    rd_idx_nxt     = rd_idx_r;
    last_idx_nxt   = last_idx_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    place_nxt      = place_r;
    res_status_nxt = res_status_r;
    res_pop_nxt    = res_pop_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;

    if (cmd.start) begin
      op_nxt       = in_mode;
      key_id_nxt   = in_job_id;
      key_pri_nxt  = in_priority;
      res_pop_nxt  = '0;
      issuing_nxt  = 1'b0;
      pend_nxt     = 1'b0;
      place_nxt    = 1'b0;
      rd_idx_nxt   = '0;
      last_idx_nxt = AW'(cnt_r - CW'(1));
      unique case (in_mode)
        pjq_pkg::MODE_INSERT: begin
          if (cnt_r == CW'(DEPTH)) begin
            res_status_nxt = pjq_pkg::ST_FULL;
          end else begin
            res_status_nxt = pjq_pkg::ST_DONE;
            cnt_nxt        = cnt_r + CW'(1);
            if (cnt_r == '0) begin
              place_nxt = 1'b1;
            end else begin
              // walk down from the tail
              issuing_nxt  = 1'b1;
              rd_idx_nxt   = AW'(cnt_r - CW'(1));
              last_idx_nxt = '0;
            end
          end
        end
        pjq_pkg::MODE_POP: begin
          if (cnt_r == '0) begin
            res_status_nxt = pjq_pkg::ST_EMPTY;
          end else begin
            res_status_nxt = pjq_pkg::ST_DONE;
            cnt_nxt        = cnt_r - CW'(1);
            issuing_nxt    = 1'b1;
          end
        end
        pjq_pkg::MODE_SEARCH: begin
          if (cnt_r == '0) begin
            res_status_nxt = pjq_pkg::ST_EMPTY;
          end else begin
            res_status_nxt = pjq_pkg::ST_NOT_FOUND;
            issuing_nxt    = 1'b1;
          end
        end
        default: res_status_nxt = pjq_pkg::ST_DONE;
      endcase
    end else if (cmd.run) begin
      // issue one read a cycle
      if (issuing_r) begin
        ram_re       = 1'b1;
        pend_nxt     = 1'b1;
        pend_idx_nxt = rd_idx_r;
        if (rd_idx_r == last_idx_r) begin
          issuing_nxt = 1'b0;
        end else if (op_r == pjq_pkg::MODE_INSERT) begin
          rd_idx_nxt = rd_idx_r - AW'(1);
        end else begin
          rd_idx_nxt = rd_idx_r + AW'(1);
        end
      end else begin
        pend_nxt = 1'b0;
      end

      // act on the entry read last cycle
      if (pend_r) begin
        unique case (op_r)
          pjq_pkg::MODE_INSERT: begin
            ram_we    = 1'b1;
            ram_waddr = pend_idx_r + AW'(1);
            if (rd_pri >= key_pri_r) begin
              // slot found behind this entry
              ram_wdata   = {key_id_r, key_pri_r};
              issuing_nxt = 1'b0;
              pend_nxt    = 1'b0;
            end else begin
              ram_wdata = ram_rdata;
              if (pend_idx_r == '0) place_nxt = 1'b1;
            end
          end
          pjq_pkg::MODE_POP: begin
            if (pend_idx_r == '0) begin
              res_pop_nxt = rd_id;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = pend_idx_r - AW'(1);
              ram_wdata = ram_rdata;
            end
          end
          pjq_pkg::MODE_SEARCH: begin
            if (rd_id == key_id_r) begin
              res_status_nxt = pjq_pkg::ST_FOUND;
              issuing_nxt    = 1'b0;
              pend_nxt       = 1'b0;
            end
          end
          default: ;
        endcase
      end

      // new job becomes the head
      if (place_r) begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {key_id_r, key_pri_r};
        place_nxt = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      issuing_r <= 1'b0;
      pend_r    <= 1'b0;
      place_r   <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      issuing_r <= issuing_nxt;
      pend_r    <= pend_nxt;
      place_r   <= place_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_id_r     <= key_id_nxt;
    key_pri_r    <= key_pri_nxt;
    rd_idx_r     <= rd_idx_nxt;
    last_idx_r   <= last_idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    res_status_r <= res_status_nxt;
    res_pop_r    <= res_pop_nxt;
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_pop_r    <= res_pop_r;
      out_occ_r    <= cnt_r;
    end
  end

endmodule

`default_nettype wire

/* src/priority_job_queue.sv */
// Full insert, empty pop/search and no-op give a result without a walk; a walk over
// n held jobs issues one RAM read per cycle, up to n reads.
// Requests are served one at a time; the next is taken in the cycle after the result
// is loaded, while that result may still wait in the output register.
// Reset: synchronous rst_n clears the job count and handshake state; entry RAM
// is not cleared, entries beyond the count are never read.
// ----------------------------------------------------------------------------
// priority_job_queue
// Sorted priority queue of jobs: insert, pop of the highest job, id search.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_job_queue #(
  parameter int DEPTH         = 16,
  parameter int ID_BITS       = 16,
  parameter int PRIORITY_BITS = 8
) (
  input wire logic   clk,
  input wire logic   rst_n,
  pjq_req_if.sink    in_ch,
  pjq_rsp_if.source  out_ch
);

  localparam int CNT_BITS = $clog2(DEPTH+1);

  pjq_pkg::dp_cmd_t cmd;
  pjq_pkg::dp_sts_t sts;

  // controller
  pjq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath
  pjq_datapath #(
    .DEPTH         (DEPTH),
    .ID_BITS       (ID_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_mode       (in_ch.mode),
    .in_job_id     (in_ch.job_id),
    .in_priority   (in_ch.priority_req),
    .out_status    (out_ch.status),
    .out_popped_id (out_ch.popped_id),
    .out_occupancy (out_ch.occupancy)
  );

endmodule

`default_nettype wire

/* src/pjq_checker.sv */
// ----------------------------------------------------------------------------
// pjq_checker
// Port-level checks on the result channel of the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_job_queue_assert.svh"

module pjq_checker #(
  parameter int DEPTH    = 16,
  parameter int ID_BITS  = 16,
  parameter int CNT_BITS = 5
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire pjq_pkg::status_t    out_status,
  input wire logic [ID_BITS-1:0]  out_popped_id,
  input wire logic [CNT_BITS-1:0] out_occupancy
);

  // no result right after reset
  `PJQ_ASSERT_ALWAYS(a_reset_clears_valid, clk, !rst_n |=> !out_valid, "valid after reset")

  // a stalled result holds
  `PJQ_ASSERT(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_popped_id) && $stable(out_occupancy), "result changed under stall")

  // a dropped insert means the queue is full
  `PJQ_ASSERT(a_full_occ, clk, rst_n, out_valid && out_status == pjq_pkg::ST_FULL |-> out_occupancy == CNT_BITS'(DEPTH), "full status without full queue")

  // empty report means nothing is held and nothing popped
  `PJQ_ASSERT(a_empty_occ, clk, rst_n, out_valid && out_status == pjq_pkg::ST_EMPTY |-> out_occupancy == '0 && out_popped_id == '0, "empty status with jobs held")

  // only a completed operation can carry a popped id
  `PJQ_ASSERT(a_pop_zero, clk, rst_n, out_valid && out_status != pjq_pkg::ST_DONE |-> out_popped_id == '0, "popped id without a pop")

endmodule

bind priority_job_queue pjq_checker #(
  .DEPTH    (DEPTH),
  .ID_BITS  (ID_BITS),
  .CNT_BITS (CNT_BITS)
) u_pjq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_popped_id (out_ch.popped_id),
  .out_occupancy (out_ch.occupancy)
);

`default_nettype wire

/* bench/tb_priority_job_queue.sv */
// ----------------------------------------------------------------------------
// tb_priority_job_queue
// Self-checking bench for the sorted priority job queue. A shadow queue
// predicts status, popped id and occupancy for every accepted request.
// Requests cover directed corners (empty, full, equal priorities, no-op) and
// random insert bursts followed by mostly pop/search runs under varying backpressure.
// ----------------------------------------------------------------------------
module tb_priority_job_queue;

  localparam int             QDEPTH     = 16;
  localparam int             IDW        = 16;
  localparam int             PRIW       = 8;
  localparam int             CNTW       = 5;
  localparam int             RAND_ITEMS = 500;      // per idling phase
  localparam int             DRAIN_WAIT = 40;       // covers a full walk of DEPTH entries
  localparam int             MAX_CYCLES = 400000;
  localparam pjq_pkg::mode_t MODE_NOP   = 2'd3;     // unused opcode, block treats as no-op

  typedef struct {
    pjq_pkg::mode_t   mode;
    logic [IDW-1:0]   job_id;
    logic [PRIW-1:0]  prio;
    bit               hold;   // wait for all results before presenting
    int               phase;
  } job_req_t;

  typedef struct {
    pjq_pkg::status_t status;
    logic [IDW-1:0]   popped_id;
    logic [CNTW-1:0]  occupancy;
  } job_rsp_t;

  logic clk;
  logic rst_n;

  pjq_req_if #(.ID_BITS(IDW), .PRIORITY_BITS(PRIW)) req_ch ();
  pjq_rsp_if #(.ID_BITS(IDW), .CNT_BITS(CNTW))      rsp_ch ();

  priority_job_queue #(
    .DEPTH        (QDEPTH),
    .ID_BITS      (IDW),
    .PRIORITY_BITS(PRIW)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch),
    .out_ch(rsp_ch)
  );

  // pending stimulus and predicted results
  job_req_t pending_reqs[$];
  job_rsp_t expected_rsps[$];
  job_req_t cur_req;
  int       cur_phase;
  int       reqs_taken;
  int       rsps_taken;
  int       mismatch_cnt;
  int       cycle_cnt;

  // shadow copy of the sorted job store
  logic [IDW-1:0]  shadow_id[QDEPTH];
  logic [PRIW-1:0] shadow_prio[QDEPTH];
  int              shadow_count;

  // Apply one request to the shadow queue and return the expected result
  function automatic job_rsp_t apply_request(job_req_t r);
    job_rsp_t res;
    int       pos;
    int       k;
    res.status    = pjq_pkg::ST_DONE;
    res.popped_id = '0;
    case (r.mode)
      pjq_pkg::MODE_INSERT: begin
        if (shadow_count >= QDEPTH) begin
          res.status = pjq_pkg::ST_FULL;
        end else begin
          // new job goes behind every job of equal or higher priority
          pos = 0;
          while (pos < shadow_count && shadow_prio[pos] >= r.prio) pos++;
          for (k = shadow_count; k > pos; k--) begin
            shadow_id[k]   = shadow_id[k-1];
            shadow_prio[k] = shadow_prio[k-1];
          end
          shadow_id[pos]   = r.job_id;
          shadow_prio[pos] = r.prio;
          shadow_count++;
        end
      end
      pjq_pkg::MODE_POP: begin
        if (shadow_count == 0) begin
          res.status = pjq_pkg::ST_EMPTY;
        end else begin
          res.popped_id = shadow_id[0];
          for (k = 1; k < shadow_count; k++) begin
            shadow_id[k-1]   = shadow_id[k];
            shadow_prio[k-1] = shadow_prio[k];
          end
          shadow_count--;
        end
      end
      pjq_pkg::MODE_SEARCH: begin
        if (shadow_count == 0) begin
          res.status = pjq_pkg::ST_EMPTY;
        end else begin
          res.status = pjq_pkg::ST_NOT_FOUND;
          for (k = 0; k < shadow_count; k++)
            if (shadow_id[k] == r.job_id) res.status = pjq_pkg::ST_FOUND;
        end
      end
      default: res.status = pjq_pkg::ST_DONE;
    endcase
    res.occupancy = shadow_count[CNTW-1:0];
    return res;
  endfunction

  // Half the time low priorities so ties are common, else the full range
  function automatic logic [PRIW-1:0] rand_prio();
    if ($urandom_range(1) == 0) return PRIW'($urandom_range(3));
    return PRIW'($urandom_range(255));
  endfunction

  task automatic push_req(pjq_pkg::mode_t m, logic [IDW-1:0] id, logic [PRIW-1:0] p,
                          bit hold, int ph);
    job_req_t r;
    r.mode   = m;
    r.job_id = id;
    r.prio   = p;
    r.hold   = hold;
    r.phase  = ph;
    pending_reqs.push_back(r);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MAX_CYCLES) begin
      $display("tb_priority_job_queue: FAIL");
      $finish;
    end
  end

  // Request driver
  always @(posedge clk) begin : drive_proc
    bit       drained;
    int       idle_pct;
    job_rsp_t rsp;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        rsp = apply_request(cur_req);
        expected_rsps.push_back(rsp);
        reqs_taken++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        drained = (reqs_taken == rsps_taken + int'(rsp_ch.valid && rsp_ch.ready));
        idle_pct = 0;
        if (pending_reqs.size() != 0)
          idle_pct = (pending_reqs[0].phase == 0) ? 37 :
                     (pending_reqs[0].phase == 1) ? 53 : 0;
        if (pending_reqs.size() != 0 && (!pending_reqs[0].hold || drained) &&
            $urandom_range(99) >= idle_pct) begin
          cur_req = pending_reqs.pop_front();
          cur_phase           <= cur_req.phase;
          req_ch.valid        <= 1'b1;
          req_ch.mode         <= cur_req.mode;
          req_ch.job_id       <= cur_req.job_id;
          req_ch.priority_req <= cur_req.prio;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin : check_proc
    job_rsp_t want;
    int       stall_pct;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsps_taken <= rsps_taken + 1;
        if (expected_rsps.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result status %0d popped_id %h occupancy %0d",
                   $time, rsp_ch.status, rsp_ch.popped_id, rsp_ch.occupancy);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_ch.status !== want.status) begin
            mismatch_cnt++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, rsp_ch.status);
          end
          if (rsp_ch.popped_id !== want.popped_id) begin
            mismatch_cnt++;
            $display("%0t: popped_id expected %h actual %h",
                     $time, want.popped_id, rsp_ch.popped_id);
          end
          if (rsp_ch.occupancy !== want.occupancy) begin
            mismatch_cnt++;
            $display("%0t: occupancy expected %0d actual %0d",
                     $time, want.occupancy, rsp_ch.occupancy);
          end
        end
      end
      stall_pct = (cur_phase == 0) ? 53 : (cur_phase == 1) ? 37 : 0;
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Stimulus, reset and end of test
  initial begin : main_proc
    logic [IDW-1:0] id;
    logic [IDW-1:0] id_pool[$];
    int             ph;
    int             n;
    int             k;
    int             burst;
    int             r;

    rst_n               = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.mode         = pjq_pkg::MODE_INSERT;
    req_ch.job_id       = '0;
    req_ch.priority_req = '0;
    rsp_ch.ready        = 1'b0;
    cur_phase           = 0;
    reqs_taken          = 0;
    rsps_taken          = 0;
    mismatch_cnt        = 0;
    shadow_count        = 0;

    // directed: empty queue, extremes, equal priorities, no-op, full queue
    push_req(pjq_pkg::MODE_SEARCH, 16'h0000, 8'h00, 1'b0, 0);
    push_req(pjq_pkg::MODE_POP,    16'h0000, 8'h00, 1'b0, 0);
    push_req(pjq_pkg::MODE_INSERT, 16'hFFFF, 8'hFF, 1'b0, 0);
    push_req(pjq_pkg::MODE_INSERT, 16'h0000, 8'h00, 1'b0, 0);
    push_req(pjq_pkg::MODE_INSERT, 16'h1234, 8'hFF, 1'b0, 0);
    push_req(pjq_pkg::MODE_SEARCH, 16'hFFFF, 8'hFF, 1'b0, 0);
    push_req(pjq_pkg::MODE_SEARCH, 16'h5555, 8'h00, 1'b0, 0);
    push_req(MODE_NOP,             16'hFFFF, 8'hFF, 1'b0, 0);
    push_req(pjq_pkg::MODE_POP,    16'hFFFF, 8'hFF, 1'b0, 0);
    push_req(pjq_pkg::MODE_POP,    16'h0000, 8'h00, 1'b0, 0);
    push_req(pjq_pkg::MODE_POP,    16'h0000, 8'h00, 1'b0, 0);
    for (k = 0; k <= QDEPTH; k++)
      push_req(pjq_pkg::MODE_INSERT, IDW'(16'hA000 + k), PRIW'(k % 4), 1'b0, 0);

    // random: insert bursts followed by mostly pop/search runs, per idling phase
    for (ph = 0; ph < 3; ph++) begin
      n = 0;
      while (n < RAND_ITEMS) begin
        burst = $urandom_range(1, 20);
        for (k = 0; k < burst; k++) begin
          id = IDW'($urandom_range(16'hFFFF));
          if ($urandom_range(4) == 0 && id_pool.size() != 0)
            id = id_pool[$urandom_range(id_pool.size() - 1)];
          push_req(pjq_pkg::MODE_INSERT, id, rand_prio(), n == 0, ph);
          id_pool.push_back(id);
          if (id_pool.size() > 32) void'(id_pool.pop_front());
          n++;
        end
        burst = $urandom_range(1, 24);
        for (k = 0; k < burst; k++) begin
          r  = $urandom_range(99);
          id = IDW'($urandom_range(16'hFFFF));
          if (r < 55) begin
            push_req(pjq_pkg::MODE_POP, id, rand_prio(), 1'b0, ph);
          end else if (r < 90) begin
            if ($urandom_range(9) < 7 && id_pool.size() != 0)
              id = id_pool[$urandom_range(id_pool.size() - 1)];
            push_req(pjq_pkg::MODE_SEARCH, id, rand_prio(), 1'b0, ph);
          end else if (r < 95) begin
            push_req(pjq_pkg::MODE_INSERT, id, rand_prio(), 1'b0, ph);
          end else begin
            push_req(MODE_NOP, id, rand_prio(), 1'b0, ph);
          end
          n++;
        end
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all requests to go out and all results to come back
    @(negedge clk);
    while (pending_reqs.size() != 0 || req_ch.valid || reqs_taken != rsps_taken)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (expected_rsps.size() != 0) begin
      mismatch_cnt++;
      $display("%0t: %0d expected results never arrived", $time, expected_rsps.size());
    end
    if (mismatch_cnt == 0)
      $display("tb_priority_job_queue: PASS");
    else
      $display("tb_priority_job_queue: FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/pjq_pkg.sv
src/pjq_req_if.sv
src/pjq_rsp_if.sv
src/pjq_ram.sv
src/pjq_ctrl.sv
src/pjq_datapath.sv
src/priority_job_queue.sv
src/pjq_checker.sv
bench/tb_priority_job_queue.sv
